// ===== hw/rtl/ensc_pkg.sv =====
package ensc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Magnitude bits each divider instance handles (gas numerator stays below 2^49)
  localparam int DivNumW = 50;
  localparam int DivLat  = DivNumW + 2;

  localparam int TempLat = 5;
  localparam int PresLat = 7 + DivLat + 4;
  localparam int HumLat  = 11;
  localparam int GasLat  = 3 + DivLat;
  localparam int PipeLat = TempLat + PresLat;

  // floor(n / 100) == (n * Recip100) >> Recip100Sh for every 32-bit n
  localparam logic [31:0] Recip100   = 32'd1374389535;
  localparam int          Recip100Sh = 37;

  typedef enum logic [CfgIdxW-1:0] {
    RegTempCal     = 3'd0,
    RegPresCalA    = 3'd1,
    RegPresCalB    = 3'd2,
    RegPresP10     = 3'd3,
    RegHumCal      = 3'd4,
    RegGasRangeErr = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  t3;
    logic [15:0] t2;
    logic [15:0] t1;
  } temp_cal_t;

  typedef struct packed {
    logic [7:0]  p10;
    logic [15:0] p9;
    logic [15:0] p8;
    logic [7:0]  p7;
    logic [7:0]  p6;
    logic [15:0] p5;
    logic [15:0] p4;
    logic [7:0]  p3;
    logic [15:0] p2;
    logic [15:0] p1;
  } pres_cal_t;

  typedef struct packed {
    logic [7:0]  h7;
    logic [7:0]  h6;
    logic [7:0]  h5;
    logic [7:0]  h4;
    logic [7:0]  h3;
    logic [11:0] h2;
    logic [11:0] h1;
  } hum_cal_t;

  // Signed division by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv32(input logic signed [31:0] a,
                                                input int unsigned k);
    logic signed [32:0] t;
    t = $signed({a[31], a}) + (a[31] ? ((33'sd1 <<< k) - 33'sd1) : 33'sd0);
    return 32'(t >>> k);
  endfunction

  function automatic logic signed [63:0] sdiv64(input logic signed [63:0] a,
                                                input int unsigned k);
    logic signed [64:0] t;
    t = $signed({a[63], a}) + (a[63] ? ((65'sd1 <<< k) - 65'sd1) : 65'sd0);
    return 64'(t >>> k);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic [31:0] gas_rom_a(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd5, 4'd13: v = 32'd2126008810;
      4'd7:        v = 32'd2130303777;
      4'd10:       v = 32'd2143188679;
      4'd11:       v = 32'd2136746228;
      default:     v = 32'd2147483647;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] gas_rom_b(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'd4096000000;
      4'd1:    v = 32'd2048000000;
      4'd2:    v = 32'd1024000000;
      4'd3:    v = 32'd512000000;
      4'd4:    v = 32'd255744255;
      4'd5:    v = 32'd127110228;
      4'd6:    v = 32'd64000000;
      4'd7:    v = 32'd32258064;
      4'd8:    v = 32'd16016016;
      4'd9:    v = 32'd8000000;
      4'd10:   v = 32'd4000000;
      4'd11:   v = 32'd2000000;
      4'd12:   v = 32'd1000000;
      4'd13:   v = 32'd500000;
      4'd14:   v = 32'd250000;
      default: v = 32'd125000;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ensc_div.sv =====
module ensc_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic [31:0]        quo
);

  localparam int W = ensc_pkg::DivNumW;

  logic [31:0]  rem_r [W+1];
  logic [W-1:0] nq_r  [W+1];
  logic [31:0]  dd_r  [W+1];
  logic         neg_r [W+1];
  logic         zro_r [W+1];
  logic [31:0]  rem_nxt [W];
  logic [W-1:0] nq_nxt  [W];
  logic [31:0]  quo_r;
  logic [63:0]  num_mag;

  assign num_mag = num[63] ? (~num + 64'd1) : num;

  // One quotient bit per stage, restoring
  always_comb begin
    logic [32:0] t;
    for (int i = 0; i < W; i++) begin
      t = {rem_r[i], nq_r[i][W-1]};
      if (t >= {1'b0, dd_r[i]}) begin
        rem_nxt[i] = 32'(t - {1'b0, dd_r[i]});
        nq_nxt[i]  = {nq_r[i][W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t[31:0];
        nq_nxt[i]  = {nq_r[i][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num_mag[W-1:0];
      dd_r[0]  <= ensc_pkg::mag32(den);
      neg_r[0] <= num[63] ^ den[31];
      zro_r[0] <= (den == 32'sd0);
      for (int i = 0; i < W; i++) begin
        rem_r[i+1] <= rem_nxt[i];
        nq_r[i+1]  <= nq_nxt[i];
        dd_r[i+1]  <= dd_r[i];
        neg_r[i+1] <= neg_r[i];
        zro_r[i+1] <= zro_r[i];
      end
      if (zro_r[W]) quo_r <= '0;
      else if (neg_r[W]) quo_r <= ~nq_r[W][31:0] + 32'd1;
      else quo_r <= nq_r[W][31:0];
    end
  end

  assign quo = quo_r;

endmodule

// ===== hw/rtl/ensc_temp.sv =====
module ensc_temp (
  input  logic                clk,
  input  logic                en,
  input  ensc_pkg::temp_cal_t cal,
  input  logic [19:0]         temp_raw,
  output logic signed [31:0]  tf,
  output logic signed [31:0]  ts
);

  logic signed [31:0] v1_r;
  logic signed [63:0] v2p_r, sq_r, v2_r, v3p_r;
  logic signed [31:0] tf_r, tfo_r, ts_r;
  logic signed [31:0] v1_nxt, hv, t5;

  always_comb begin
    v1_nxt = $signed({15'd0, temp_raw[19:3]}) - $signed({15'd0, cal.t1, 1'b0});
    hv     = ensc_pkg::sdiv32(v1_r, 1);
    t5     = tf_r * 32'sd5 + 32'sd128;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r  <= v1_nxt;
      v2p_r <= 64'(v1_r) * 64'($signed(cal.t2));
      sq_r  <= 64'(hv) * 64'(hv);
      v2_r  <= ensc_pkg::sdiv64(v2p_r, 11);
      v3p_r <= ensc_pkg::sdiv64(sq_r, 12) * (64'($signed(cal.t3)) <<< 4);
      tf_r  <= 32'(v2_r + ensc_pkg::sdiv64(v3p_r, 14));
      tfo_r <= tf_r;
      ts_r  <= ensc_pkg::sdiv32(t5, 8);
    end
  end

  assign tf = tfo_r;
  assign ts = ts_r;

endmodule

// ===== hw/rtl/ensc_pres.sv =====
module ensc_pres (
  input  logic                clk,
  input  logic                en,
  input  ensc_pkg::pres_cal_t cal,
  input  logic signed [31:0]  tf,
  input  logic [19:0]         padc,
  output logic [31:0]         pressure
);

  logic signed [31:0] a1_r, q1_r;
  logic signed [31:0] sq2_r, m2_r;
  logic signed [31:0] v2a3_r, v1b3_r, m3_r;
  logic signed [31:0] t14_r, t24_r, t34_r, m4_r;
  logic signed [31:0] v2c5_r, v1d5_r;
  logic signed [31:0] m6_r, cpa6_r;
  logic signed [31:0] v1e7_r, cpb7_r;
  logic signed [31:0] pc1_r, pc2_r, pc3_r, pc4_r, pc5_r;
  logic signed [31:0] x8_r, y8_r, z8_r, cp8_r, c2568_r;
  logic signed [31:0] xq9_r, y9_r, zz9_r, cp9_r;
  logic signed [31:0] v1p10_r, v3a10_r, y10_r, cp10_r;
  logic signed [31:0] pres_r;
  logic signed [31:0] a1_nxt, v2b, v1c, cp, c8, c4, c256, sum;
  logic [31:0]        qd;

  always_comb begin
    a1_nxt = ensc_pkg::sdiv32(tf, 1) - 32'sd64000;
    v2b    = ensc_pkg::sdiv32(t14_r, 2) + m4_r;
    v1c    = ensc_pkg::sdiv32(t24_r, 3) + ensc_pkg::sdiv32(t34_r, 1);
    cp     = $signed(qd) <<< 1;
    c8     = ensc_pkg::sdiv32(cp, 3);
    c4     = ensc_pkg::sdiv32(cp, 2);
    c256   = ensc_pkg::sdiv32(cp, 8);
    sum    = ensc_pkg::sdiv32(v1p10_r, 12) + y10_r + ensc_pkg::sdiv32(v3a10_r, 17)
             + (32'($signed(cal.p7)) <<< 7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= a1_nxt;
      q1_r    <= ensc_pkg::sdiv32(a1_nxt, 2);
      pc1_r   <= 32'sd1048576 - $signed({12'd0, padc});
      sq2_r   <= q1_r * q1_r;
      m2_r    <= a1_r * 32'($signed(cal.p5));
      pc2_r   <= pc1_r;
      v2a3_r  <= ensc_pkg::sdiv32(sq2_r, 11);
      v1b3_r  <= ensc_pkg::sdiv32(sq2_r, 13);
      m3_r    <= m2_r <<< 1;
      pc3_r   <= pc2_r;
      t14_r   <= v2a3_r * 32'($signed(cal.p6));
      t24_r   <= v1b3_r * (32'($signed(cal.p3)) <<< 5);
      t34_r   <= 32'($signed(cal.p2)) * v1b3_r;
      m4_r    <= m3_r;
      pc4_r   <= pc3_r;
      v2c5_r  <= ensc_pkg::sdiv32(v2b, 2) + (32'($signed(cal.p4)) <<< 16);
      v1d5_r  <= ensc_pkg::sdiv32(v1c, 18);
      pc5_r   <= pc4_r;
      m6_r    <= (32'sd32768 + v1d5_r) * $signed({16'd0, cal.p1});
      cpa6_r  <= pc5_r - ensc_pkg::sdiv32(v2c5_r, 12);
      v1e7_r  <= ensc_pkg::sdiv32(m6_r, 15);
      cpb7_r  <= cpa6_r * 32'sd3125;
      x8_r    <= c8 * c8;
      y8_r    <= c4 * 32'($signed(cal.p8));
      z8_r    <= c256 * c256;
      cp8_r   <= cp;
      c2568_r <= c256;
      xq9_r   <= ensc_pkg::sdiv32(x8_r, 13);
      y9_r    <= ensc_pkg::sdiv32(y8_r, 13);
      zz9_r   <= z8_r * c2568_r;
      cp9_r   <= cp8_r;
      v1p10_r <= 32'($signed(cal.p9)) * xq9_r;
      v3a10_r <= zz9_r * $signed({24'd0, cal.p10});
      y10_r   <= y9_r;
      cp10_r  <= cp9_r;
      pres_r  <= cp10_r + ensc_pkg::sdiv32(sum, 4);
    end
  end

  ensc_div u_div (
    .clk (clk),
    .en  (en),
    .num (64'(cpb7_r)),
    .den (v1e7_r),
    .quo (qd)
  );

  assign pressure = pres_r;

endmodule

// ===== hw/rtl/ensc_hum.sv =====
module ensc_hum (
  input  logic               clk,
  input  logic               en,
  input  ensc_pkg::hum_cal_t cal,
  input  logic signed [31:0] ts,
  input  logic [15:0]        hadc,
  output logic [16:0]        humidity
);

  function automatic logic signed [31:0] quo100(input logic [63:0] prod, input logic neg);
    logic [31:0] m;
    m = 32'(prod >> ensc_pkg::Recip100Sh);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  logic signed [31:0] a3_r, a4_r, a5_r, a7_r, ts1_r, ts2_r;
  logic [15:0]        hadc1_r, hadc2_r;
  logic [63:0]        p3_r, p4_r, p5_r, p7_r, pb4_r;
  logic               n3_r, n4_r, n5_r, n7_r, nb4_r;
  logic signed [31:0] b3_r, v1_3_r, v4_3_r, q4_3_r;
  logic signed [31:0] v1_4_r, v4_4_r, q4_4_r;
  logic signed [31:0] v2s5_r, v1_5_r, v4_5_r;
  logic signed [31:0] m6_r, v1_6_r, v4_6_r;
  logic signed [31:0] v3_7_r, v4_7_r;
  logic signed [31:0] sq8_r, v3_8_r, v4_8_r;
  logic signed [31:0] p9_r, v3_9_r;
  logic signed [31:0] hm10_r;
  logic [16:0]        hum_r;
  logic signed [31:0] q3, q5, q7, b64, v3s, v5, v6, s, h;

  always_comb begin
    q3  = quo100(p3_r, n3_r);
    q5  = quo100(p5_r, n5_r);
    q7  = quo100(p7_r, n7_r);
    b64 = ensc_pkg::sdiv32(b3_r, 6);
    v3s = ensc_pkg::sdiv32(v3_7_r, 14);
    v5  = ensc_pkg::sdiv32(sq8_r, 10);
    v6  = ensc_pkg::sdiv32(p9_r, 1);
    s   = ensc_pkg::sdiv32(v3_9_r + v6, 10);
    h   = ensc_pkg::sdiv32(hm10_r, 12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r    <= ts * 32'($signed(cal.h3));
      a4_r    <= ts * 32'($signed(cal.h4));
      a5_r    <= ts * 32'($signed(cal.h5));
      a7_r    <= ts * 32'($signed(cal.h7));
      ts1_r   <= ts;
      hadc1_r <= hadc;
      p3_r    <= 64'(ensc_pkg::mag32(a3_r)) * 64'(ensc_pkg::Recip100);
      p4_r    <= 64'(ensc_pkg::mag32(a4_r)) * 64'(ensc_pkg::Recip100);
      p5_r    <= 64'(ensc_pkg::mag32(a5_r)) * 64'(ensc_pkg::Recip100);
      p7_r    <= 64'(ensc_pkg::mag32(a7_r)) * 64'(ensc_pkg::Recip100);
      n3_r    <= a3_r[31];
      n4_r    <= a4_r[31];
      n5_r    <= a5_r[31];
      n7_r    <= a7_r[31];
      ts2_r   <= ts1_r;
      hadc2_r <= hadc1_r;
      b3_r    <= ts2_r * q5;
      v1_3_r  <= $signed({16'd0, hadc2_r}) - $signed({16'd0, cal.h1, 4'd0})
                 - ensc_pkg::sdiv32(q3, 1);
      v4_3_r  <= ensc_pkg::sdiv32($signed({17'd0, cal.h6, 7'd0}) + q7, 4);
      q4_3_r  <= quo100(p4_r, n4_r);
      pb4_r   <= 64'(ensc_pkg::mag32(b64)) * 64'(ensc_pkg::Recip100);
      nb4_r   <= b64[31];
      v1_4_r  <= v1_3_r;
      v4_4_r  <= v4_3_r;
      q4_4_r  <= q4_3_r;
      v2s5_r  <= q4_4_r + quo100(pb4_r, nb4_r) + 32'sd16384;
      v1_5_r  <= v1_4_r;
      v4_5_r  <= v4_4_r;
      m6_r    <= $signed({20'd0, cal.h2}) * v2s5_r;
      v1_6_r  <= v1_5_r;
      v4_6_r  <= v4_5_r;
      v3_7_r  <= v1_6_r * ensc_pkg::sdiv32(m6_r, 10);
      v4_7_r  <= v4_6_r;
      sq8_r   <= v3s * v3s;
      v3_8_r  <= v3_7_r;
      v4_8_r  <= v4_7_r;
      p9_r    <= v4_8_r * v5;
      v3_9_r  <= v3_8_r;
      hm10_r  <= s * 32'sd1000;
      if (h > 32'sd100000) hum_r <= 17'd100000;
      else if (h < 32'sd0) hum_r <= '0;
      else hum_r <= h[16:0];
    end
  end

  assign humidity = hum_r;

endmodule

// ===== hw/rtl/ensc_gas.sv =====
module ensc_gas (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  range_err,
  input  logic [9:0]  gas_raw,
  input  logic [3:0]  range_idx,
  output logic [31:0] gas_res
);

  logic signed [11:0] e_s;
  logic [42:0]        g1p1_r;
  logic [31:0]        gb1_r;
  logic [9:0]         gadc1_r;
  logic [26:0]        g1;
  logic [58:0]        g3p2_r;
  logic signed [31:0] g22_r;
  logic signed [63:0] num3_r;
  logic signed [31:0] den3_r;

  always_comb begin
    e_s = 12'sd1340 + 12'sd5 * 12'($signed(range_err));
    g1  = g1p1_r[42:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1p1_r  <= 43'(e_s[10:0]) * 43'(ensc_pkg::gas_rom_a(range_idx));
      gb1_r   <= ensc_pkg::gas_rom_b(range_idx);
      gadc1_r <= gas_raw;
      g3p2_r  <= 59'(gb1_r) * 59'(g1);
      g22_r   <= $signed({7'd0, gadc1_r, 15'd0}) - 32'sd16777216 + $signed({5'd0, g1});
      num3_r  <= $signed({14'd0, g3p2_r[58:9]}) + 64'(ensc_pkg::sdiv32(g22_r, 1));
      den3_r  <= g22_r;
    end
  end

  ensc_div u_div (
    .clk (clk),
    .en  (en),
    .num (num3_r),
    .den (den3_r),
    .quo (gas_res)
  );

endmodule

// ===== hw/rtl/env_sensor_compensation_core.sv =====
// Environmental sensor compensation core.
// Input channel (in_valid / in_stall) takes one raw reading per item: pressure,
// temperature, humidity and gas ADC codes, the gas range index and the new-data
// flag. A reading with new-data clear is dropped and gives no result.
// Result channel (out_valid / out_stall) returns temperature (0.01 degC),
// pressure (Pa), humidity (0.001 %rH) and gas resistance (ohm).
// Calibration is loaded through cfg_wr_en / cfg_index / cfg_wr_data while the
// core is idle; register 0 temp, 1 and 2 pressure, 3 p10, 4 humidity, 5 gas.
// Throughput: one item per cycle unless out_stall holds a waiting result. The
// result path is the temperature stages followed by the pressure path and its
// pipelined divider (one quotient bit per stage).
// The whole pipeline advances as one; when out_stall holds a waiting result,
// every stage holds and in_stall rises, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and all calibration
// registers to zero.
module env_sensor_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [19:0]                   in_pres_raw,
  input  logic [19:0]                   in_temp_raw,
  input  logic [15:0]                   in_hum_raw,
  input  logic [9:0]                    in_gas_raw,
  input  logic [3:0]                    in_gas_range_index,
  input  logic                          in_fresh,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_temperature,
  output logic [31:0]                   out_pressure,
  output logic [16:0]                   out_humidity,
  output logic [31:0]                   out_gas_resistance,
  input  logic                          cfg_wr_en,
  input  logic [ensc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ensc_pkg::CfgDataW-1:0] cfg_wr_data
);

  localparam int TempDly = ensc_pkg::PresLat;
  localparam int HumDly  = ensc_pkg::PresLat - ensc_pkg::HumLat;
  localparam int GasDly  = ensc_pkg::PipeLat - ensc_pkg::GasLat;
  localparam int RawDly  = ensc_pkg::TempLat;

  logic [39:0] temp_cal_r;
  logic [55:0] pres_cal_a_r;
  logic [63:0] pres_cal_b_r;
  logic [7:0]  pres_p10_r;
  logic [63:0] hum_cal_r;
  logic [3:0]  gas_err_r;

  logic adv;
  logic s0_valid_r;
  logic [19:0] s0_pres_r, s0_temp_r;
  logic [15:0] s0_hum_r;
  logic [9:0]  s0_gas_r;
  logic [3:0]  s0_rng_r;

  logic [ensc_pkg::PipeLat-1:0] vld_r;
  logic [19:0] pres_d_r [RawDly];
  logic [15:0] hum_raw_d_r [RawDly];
  logic [15:0] temp_d_r [TempDly];
  logic [16:0] hum_d_r [HumDly];
  logic [31:0] gas_d_r [GasDly];

  logic signed [31:0] tf, ts;
  logic [31:0] pressure, gas_res;
  logic [16:0] humidity;

  logic out_valid_r;
  logic signed [15:0] out_temp_r;
  logic [31:0] out_pres_r, out_gas_r;
  logic [16:0] out_hum_r;

  ensc_pkg::temp_cal_t tcal;
  ensc_pkg::pres_cal_t pcal;
  ensc_pkg::hum_cal_t  hcal;

  assign tcal = ensc_pkg::temp_cal_t'(temp_cal_r);
  assign pcal = ensc_pkg::pres_cal_t'({pres_p10_r, pres_cal_b_r, pres_cal_a_r});
  assign hcal = ensc_pkg::hum_cal_t'(hum_cal_r);

  // Hold every stage while a finished result waits
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      pres_cal_a_r <= '0;
      pres_cal_b_r <= '0;
      pres_p10_r   <= '0;
      hum_cal_r    <= '0;
      gas_err_r    <= '0;
    end else if (cfg_wr_en) begin
      case (ensc_pkg::cfg_reg_t'(cfg_index))
        ensc_pkg::RegTempCal:     temp_cal_r   <= cfg_wr_data[39:0];
        ensc_pkg::RegPresCalA:    pres_cal_a_r <= cfg_wr_data[55:0];
        ensc_pkg::RegPresCalB:    pres_cal_b_r <= cfg_wr_data;
        ensc_pkg::RegPresP10:     pres_p10_r   <= cfg_wr_data[7:0];
        ensc_pkg::RegHumCal:      hum_cal_r    <= cfg_wr_data;
        ensc_pkg::RegGasRangeErr: gas_err_r    <= cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r  <= in_valid && in_fresh;
      vld_r       <= {vld_r[ensc_pkg::PipeLat-2:0], s0_valid_r};
      out_valid_r <= vld_r[ensc_pkg::PipeLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_pres_r <= in_pres_raw;
      s0_temp_r <= in_temp_raw;
      s0_hum_r  <= in_hum_raw;
      s0_gas_r  <= in_gas_raw;
      s0_rng_r  <= in_gas_range_index;
      pres_d_r[0]    <= s0_pres_r;
      hum_raw_d_r[0] <= s0_hum_r;
      for (int k = 1; k < RawDly; k++) begin
        pres_d_r[k]    <= pres_d_r[k-1];
        hum_raw_d_r[k] <= hum_raw_d_r[k-1];
      end
      temp_d_r[0] <= ts[15:0];
      for (int k = 1; k < TempDly; k++) temp_d_r[k] <= temp_d_r[k-1];
      hum_d_r[0] <= humidity;
      for (int k = 1; k < HumDly; k++) hum_d_r[k] <= hum_d_r[k-1];
      gas_d_r[0] <= gas_res;
      for (int k = 1; k < GasDly; k++) gas_d_r[k] <= gas_d_r[k-1];
      out_temp_r <= $signed(temp_d_r[TempDly-1]);
      out_pres_r <= pressure;
      out_hum_r  <= hum_d_r[HumDly-1];
      out_gas_r  <= gas_d_r[GasDly-1];
    end
  end

  ensc_temp u_temp (
    .clk      (clk),
    .en       (adv),
    .cal      (tcal),
    .temp_raw (s0_temp_r),
    .tf       (tf),
    .ts       (ts)
  );

  ensc_pres u_pres (
    .clk      (clk),
    .en       (adv),
    .cal      (pcal),
    .tf       (tf),
    .padc     (pres_d_r[RawDly-1]),
    .pressure (pressure)
  );

  ensc_hum u_hum (
    .clk      (clk),
    .en       (adv),
    .cal      (hcal),
    .ts       (ts),
    .hadc     (hum_raw_d_r[RawDly-1]),
    .humidity (humidity)
  );

  ensc_gas u_gas (
    .clk       (clk),
    .en        (adv),
    .range_err (gas_err_r),
    .gas_raw   (s0_gas_r),
    .range_idx (s0_rng_r),
    .gas_res   (gas_res)
  );

  assign out_valid          = out_valid_r;
  assign out_temperature    = out_temp_r;
  assign out_pressure       = out_pres_r;
  assign out_humidity       = out_hum_r;
  assign out_gas_resistance = out_gas_r;

endmodule
